// ===== hdl/pgpg_pkg.sv =====
// Shared types, constants and multiply helpers for the polar Gaussian pair generator.
package pgpg_pkg;

  localparam int DEF_INPUT_BITS  = 32;
  localparam int DEF_OUTPUT_BITS = 32;
  localparam int LOG_FRAC        = 56;
  localparam int ROOT_FRAC       = 28;
  localparam int NORM_STEPS      = 6;
  localparam int DIV_STEPS       = 64;
  localparam int ROOT_STEPS      = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } mulpp_t;

  // classified request handed from the front end to the back end
  typedef struct packed {
    logic [63:0] sq_a;
    logic [63:0] sq_b;
    logic [63:0] sum;
    logic        neg_a;
    logic        neg_b;
    logic        zero;
  } item_t;

  function automatic mulpp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    mulpp_t r;
    r.ll = a[31:0]  * b[31:0];
    r.lh = a[31:0]  * b[63:32];
    r.hl = a[63:32] * b[31:0];
    r.hh = a[63:32] * b[63:32];
    return r;
  endfunction

  // exact high half of the 128-bit product
  function automatic logic [63:0] mul_hi_sum(input mulpp_t p);
    logic [127:0] acc;
    acc = {p.hh, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0};
    return acc[127:64];
  endfunction

endpackage

// ===== hdl/pgpg_front.sv =====
// Front end: centers the uniforms, squares them and drops rejected pairs.
module pgpg_front import pgpg_pkg::*; #(
  parameter int INPUT_BITS = DEF_INPUT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INPUT_BITS-1:0] uniform_a,
  input  logic [INPUT_BITS-1:0] uniform_b,
  input  logic                  q_full,
  output logic                  push,
  output item_t                 push_item
);

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  logic [31:0] ua, ub;
  logic [32:0] ca, cb;
  logic        na, nb;

  logic        v1;
  logic        big_a, big_b, neg_a, neg_b;
  logic [31:0] lo_a, lo_b;
  logic [63:0] sq_a, sq_b;

  logic [64:0] sum;
  logic        keep, zero;

  assign in_ready = !(v1 && q_full);

  always_comb begin
    ua = 32'(uniform_a) << (32 - INPUT_BITS);
    ub = 32'(uniform_b) << (32 - INPUT_BITS);
    na = !ua[31];
    nb = !ub[31];
    ca = ua[31] ? {1'b0, ua[30:0], 1'b0} : ONE_Q32 - {1'b0, ua[30:0], 1'b0};
    cb = ub[31] ? {1'b0, ub[30:0], 1'b0} : ONE_Q32 - {1'b0, ub[30:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      big_a <= ca[32];
      big_b <= cb[32];
      lo_a  <= ca[31:0];
      lo_b  <= cb[31:0];
      neg_a <= na;
      neg_b <= nb;
      sq_a  <= ca[31:0] * ca[31:0];
      sq_b  <= cb[31:0] * cb[31:0];
    end
  end

  always_comb begin
    sum = {1'b0, sq_a} + {1'b0, sq_b};
    if (big_a || big_b) begin
      // one variate at full scale: only W exactly one survives
      keep = big_a ? (!big_b && lo_b == '0) : (lo_a == '0);
      zero = 1'b1;
    end else if (sum[64]) begin
      keep = (sum[63:0] == '0);
      zero = 1'b1;
    end else begin
      keep = (sum[63:0] != '0);
      zero = 1'b0;
    end
  end

  assign push = v1 && keep && !q_full;

  always_comb begin
    push_item.sq_a  = sq_a;
    push_item.sq_b  = sq_b;
    push_item.sum   = sum[63:0];
    push_item.neg_a = neg_a;
    push_item.neg_b = neg_b;
    push_item.zero  = zero;
  end

endmodule

// ===== hdl/pgpg_queue.sv =====
// Short request queue between front end and back end.
module pgpg_queue import pgpg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
  end

endmodule

// ===== hdl/pgpg_log.sv =====
// Back end log unit: -2 ln W by normalize, repeated squaring and a ln2 scale.
module pgpg_log import pgpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        out_valid,
  output item_t       out_item,
  output logic [63:0] out_t
);

  // normalize stages
  logic          nv    [NORM_STEPS];
  logic [63:0]   nm    [NORM_STEPS];
  logic [5:0]    nz    [NORM_STEPS];
  item_t         nitem [NORM_STEPS];

  // squaring steps, two stages each
  logic                av    [LOG_FRAC];
  mulpp_t              app   [LOG_FRAC];
  logic [LOG_FRAC-1:0] af    [LOG_FRAC];
  logic [5:0]          az    [LOG_FRAC];
  item_t               aitem [LOG_FRAC];
  logic                bv    [LOG_FRAC];
  logic [63:0]         bm    [LOG_FRAC];
  logic [LOG_FRAC-1:0] bf    [LOG_FRAC];
  logic [5:0]          bz    [LOG_FRAC];
  item_t               bitem [LOG_FRAC];

  logic        lv_a, lv_b;
  mulpp_t      lpp;
  item_t       litem_a, litem_b;
  logic [63:0] neg_log2;

  for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
    localparam int SH = 32 >> g;
    logic        sv;
    logic [63:0] sm;
    logic [5:0]  sz;
    item_t       si;
    if (g == 0) begin : g_first
      assign sv = in_valid;
      assign sm = in_item.sum;
      assign sz = '0;
      assign si = in_item;
    end else begin : g_next
      assign sv = nv[g-1];
      assign sm = nm[g-1];
      assign sz = nz[g-1];
      assign si = nitem[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[g] <= 1'b0;
      end else if (en) begin
        nv[g] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nitem[g] <= si;
        if (sm[63 -: SH] == '0) begin
          nm[g] <= sm << SH;
          nz[g] <= sz + 6'(SH);
        end else begin
          nm[g] <= sm;
          nz[g] <= sz;
        end
      end
    end
  end

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
    logic                sv;
    logic [63:0]         sm;
    logic [LOG_FRAC-1:0] sf;
    logic [5:0]          sz;
    item_t               si;
    logic [63:0]         p;
    if (g == 0) begin : g_first
      assign sv = nv[NORM_STEPS-1];
      assign sm = nm[NORM_STEPS-1];
      assign sf = '0;
      assign sz = nz[NORM_STEPS-1];
      assign si = nitem[NORM_STEPS-1];
    end else begin : g_next
      assign sv = bv[g-1];
      assign sm = bm[g-1];
      assign sf = bf[g-1];
      assign sz = bz[g-1];
      assign si = bitem[g-1];
    end

    assign p = mul_hi_sum(app[g]);

    always_ff @(posedge clk) begin
      if (rst) begin
        av[g] <= 1'b0;
        bv[g] <= 1'b0;
      end else if (en) begin
        av[g] <= sv;
        bv[g] <= av[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        app[g]   <= mul_parts(sm, sm);
        af[g]    <= sf;
        az[g]    <= sz;
        aitem[g] <= si;
        // square at or above two: take the bit and renormalize
        bm[g]    <= p[63] ? p : (p << 1);
        bf[g]    <= {af[g][LOG_FRAC-2:0], p[63]};
        bz[g]    <= az[g];
        bitem[g] <= aitem[g];
      end
    end
  end

  assign neg_log2 = (64'(7'(bz[LOG_FRAC-1]) + 7'd1) << LOG_FRAC) - 64'(bf[LOG_FRAC-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lv_a <= 1'b0;
      lv_b <= 1'b0;
    end else if (en) begin
      lv_a <= bv[LOG_FRAC-1];
      lv_b <= lv_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lpp     <= mul_parts(neg_log2, LN2_Q64);
      litem_a <= bitem[LOG_FRAC-1];
      out_t   <= mul_hi_sum(lpp) << 1;
      litem_b <= litem_a;
    end
  end

  assign out_valid = lv_b;
  assign out_item  = litem_b;

endmodule

// ===== hdl/pgpg_lane.sv =====
// Back end lane: V^2/W division, scale by -2 ln W, square root and output format.
module pgpg_lane import pgpg_pkg::*; #(
  parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [63:0]                   num,
  input  logic [63:0]                   den,
  input  logic [63:0]                   t,
  input  logic                          neg,
  input  logic                          zero,
  output logic                          out_valid,
  output logic signed [OUTPUT_BITS-1:0] result
);

  localparam int FRAC_BITS = OUTPUT_BITS - 6;
  localparam int SH_DN = (FRAC_BITS < ROOT_FRAC) ? ROOT_FRAC - FRAC_BITS : 1;
  localparam int SH_UP = (FRAC_BITS >= ROOT_FRAC) ? FRAC_BITS - ROOT_FRAC : 0;
  localparam logic [63:0] RND = 64'(1) << (SH_DN - 1);
  localparam logic [63:0] MAXPOS = (64'(1) << (OUTPUT_BITS - 1)) - 64'(1);

  logic        dv    [DIV_STEPS];
  logic [63:0] drem  [DIV_STEPS];
  logic [63:0] dq    [DIV_STEPS];
  logic [63:0] dden  [DIV_STEPS];
  logic [63:0] dt    [DIV_STEPS];
  logic        dneg  [DIV_STEPS];
  logic        dzero [DIV_STEPS];

  logic        mv_a, mv_b, mneg_a, mneg_b, mzero_a, mzero_b;
  mulpp_t      mpp;
  logic [63:0] msq;

  logic        rv    [ROOT_STEPS];
  logic [63:0] rnum  [ROOT_STEPS];
  logic [63:0] rres  [ROOT_STEPS];
  logic        rneg  [ROOT_STEPS];
  logic        rzero [ROOT_STEPS];

  logic [63:0] mag, limit, word;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic        sv, sn, sz, take;
    logic [63:0] srem, sq, sd, st, sh;
    if (g == 0) begin : g_first
      assign sv   = in_valid;
      assign srem = num;
      assign sq   = '0;
      assign sd   = den;
      assign st   = t;
      assign sn   = neg;
      assign sz   = zero;
    end else begin : g_next
      assign sv   = dv[g-1];
      assign srem = drem[g-1];
      assign sq   = dq[g-1];
      assign sd   = dden[g-1];
      assign st   = dt[g-1];
      assign sn   = dneg[g-1];
      assign sz   = dzero[g-1];
    end

    assign sh   = srem << 1;
    assign take = srem[63] || (sh >= sd);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g] <= 1'b0;
      end else if (en) begin
        dv[g] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[g]  <= take ? sh - sd : sh;
        dq[g]    <= {sq[62:0], take};
        dden[g]  <= sd;
        dt[g]    <= st;
        dneg[g]  <= sn;
        dzero[g] <= sz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv_a <= 1'b0;
      mv_b <= 1'b0;
    end else if (en) begin
      mv_a <= dv[DIV_STEPS-1];
      mv_b <= mv_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mpp     <= mul_parts(dq[DIV_STEPS-1], dt[DIV_STEPS-1]);
      mneg_a  <= dneg[DIV_STEPS-1];
      mzero_a <= dzero[DIV_STEPS-1];
      msq     <= mul_hi_sum(mpp);
      mneg_b  <= mneg_a;
      mzero_b <= mzero_a;
    end
  end

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    localparam logic [63:0] RBIT = 64'(1) << (62 - 2 * g);
    logic        sv, sn, sz;
    logic [63:0] snum, sres, trial;
    if (g == 0) begin : g_first
      assign sv   = mv_b;
      assign snum = msq;
      assign sres = '0;
      assign sn   = mneg_b;
      assign sz   = mzero_b;
    end else begin : g_next
      assign sv   = rv[g-1];
      assign snum = rnum[g-1];
      assign sres = rres[g-1];
      assign sn   = rneg[g-1];
      assign sz   = rzero[g-1];
    end

    assign trial = sres + RBIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[g] <= 1'b0;
      end else if (en) begin
        rv[g] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rneg[g]  <= sn;
        rzero[g] <= sz;
        if (snum >= trial) begin
          rnum[g] <= snum - trial;
          rres[g] <= (sres >> 1) + RBIT;
        end else begin
          rnum[g] <= snum;
          rres[g] <= sres >> 1;
        end
      end
    end
  end

  always_comb begin
    if (FRAC_BITS < ROOT_FRAC) begin
      mag = (64'(rres[ROOT_STEPS-1][31:0]) + RND) >> SH_DN;
    end else begin
      mag = 64'(rres[ROOT_STEPS-1][31:0]) << SH_UP;
    end
    limit = rneg[ROOT_STEPS-1] ? MAXPOS + 64'(1) : MAXPOS;
    if (mag > limit) begin
      mag = limit;
    end
    word = rneg[ROOT_STEPS-1] ? (~mag + 64'(1)) : mag;
  end

  assign out_valid = rv[ROOT_STEPS-1];
  assign result    = rzero[ROOT_STEPS-1] ? '0 : word[OUTPUT_BITS-1:0];

endmodule

// ===== hdl/polar_gaussian_pair_generator.sv =====
// Throughput: one uniform pair per cycle while the queue is not full (back-pressure on
// m_tready fills it); rejected pairs yield no result and leave a gap. Most of the depth
// comes from the 56 two-stage squaring steps of the log, the 64-step divider and the
// 32-step square root, all fully pipelined.
// Reset (synchronous, active high) clears valid bits, queue pointers and m_tvalid;
// the block accepts requests in the first cycle after reset.
module polar_gaussian_pair_generator import pgpg_pkg::*; #(
  parameter int INPUT_BITS  = DEF_INPUT_BITS,
  parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // uniform_a, uniform_b
  input  logic [((2 * INPUT_BITS + 7) / 8) * 8 - 1:0]  s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // normal_a, normal_b
  output logic [((2 * OUTPUT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int IN_W  = ((2 * INPUT_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * OUTPUT_BITS + 7) / 8) * 8;

  logic  push, q_full, q_empty, pop, en;
  item_t push_item, head;

  logic        log_valid;
  item_t       log_item;
  logic [63:0] log_t;

  logic                          va, vb;
  logic signed [OUTPUT_BITS-1:0] ra, rb;
  logic signed [OUTPUT_BITS-1:0] normal_a, normal_b;

  pgpg_front #(.INPUT_BITS(INPUT_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .uniform_a (s_tdata[INPUT_BITS-1:0]),
    .uniform_b (s_tdata[2*INPUT_BITS-1:INPUT_BITS]),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  pgpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  // back end advances whenever the output register can take a new value
  assign en  = !m_tvalid || m_tready;
  assign pop = en && !q_empty;

  pgpg_log u_log (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop),
    .in_item   (head),
    .out_valid (log_valid),
    .out_item  (log_item),
    .out_t     (log_t)
  );

  pgpg_lane #(.OUTPUT_BITS(OUTPUT_BITS)) u_lane_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (log_valid),
    .num       (log_item.sq_a),
    .den       (log_item.sum),
    .t         (log_t),
    .neg       (log_item.neg_a),
    .zero      (log_item.zero),
    .out_valid (va),
    .result    (ra)
  );

  pgpg_lane #(.OUTPUT_BITS(OUTPUT_BITS)) u_lane_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (log_valid),
    .num       (log_item.sq_b),
    .den       (log_item.sum),
    .t         (log_t),
    .neg       (log_item.neg_b),
    .zero      (log_item.zero),
    .out_valid (vb),
    .result    (rb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= va && vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_a <= ra;
      normal_b <= rb;
    end
  end

  assign m_tdata = OUT_W'({normal_b, normal_a});

endmodule

// ===== hdl/pgpg_checker.sv =====
// Port-level checker for the polar Gaussian pair generator, bound to the top level.
module pgpg_checker #(
  parameter int IN_W  = 64,
  parameter int OUT_W = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // requests minus results; sticks once saturated
  logic [15:0] pending;
  logic        acc, dlv;

  assign acc = s_tvalid && s_tready;
  assign dlv = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (pending != '1) begin
      if (acc && !dlv) begin
        pending <= pending + 1'b1;
      end else if (dlv && !acc) begin
        pending <= pending - 1'b1;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid set right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    dlv |-> (pending != '0) || acc)
    else $error("result with no request behind it");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

endmodule

bind polar_gaussian_pair_generator pgpg_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_pgpg_checker (.*);
